>>> rtl/skf_pkg.sv
// shared types and constants for the scalar kalman filter core
package skf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int unsigned RST_PROCESS_NOISE = 32'd655;
  localparam int unsigned RST_MEAS_NOISE    = 32'd299500;
  localparam int unsigned RST_INIT_VARIANCE = 32'd65536;

  localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [1:0] REG_MEAS_NOISE    = 2'd1;
  localparam logic [1:0] REG_INIT_VARIANCE = 2'd2;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL_EST,
    ST_MUL_VAR,
    ST_OUT
  } state_t;

endpackage

>>> rtl/skf_iter_unit.sv
// shared iterative unit: restoring fractional divide and shift-add fractional multiply
module skf_iter_unit #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  skf_pkg::cmd_t         cmd,
  input  logic [DATA_WIDTH-1:0] opnd_a,
  input  logic [DATA_WIDTH:0]   opnd_den,
  input  logic [FRAC_BITS:0]    opnd_k,
  output logic                  done,
  output logic [FRAC_BITS:0]    quot,
  output logic [DATA_WIDTH-1:0] prod
);

  localparam int AW = DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam logic [CW-1:0] LAST = CW'(FRAC_BITS);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  skf_pkg::op_t        op_r, op_nxt;
  logic [AW-1:0]       acc_r, acc_nxt;
  logic [FRAC_BITS:0]  bits_r, bits_nxt;
  logic [DATA_WIDTH:0] opb_r, opb_nxt;

  logic [AW-1:0] add_a, add_b, acc_keep;
  logic [AW:0]   add_s;
  logic          ge;

  always_comb begin
    add_a = (op_r == skf_pkg::OP_DIV) ? acc_r : {acc_r[AW-2:0], 1'b0};
    if (op_r == skf_pkg::OP_DIV) begin
      add_b = ~AW'(opb_r);
    end else begin
      add_b = bits_r[FRAC_BITS] ? AW'(opb_r) : '0;
    end
    add_s = {1'b0, add_a} + {1'b0, add_b} + (AW + 1)'(op_r == skf_pkg::OP_DIV);
    ge    = add_s[AW];
    acc_keep = ge ? add_s[AW-1:0] : acc_r;

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    bits_nxt = bits_r;
    opb_nxt  = opb_r;
    done_nxt = 1'b0;

    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      op_nxt   = cmd.op;
      if (cmd.op == skf_pkg::OP_DIV) begin
        acc_nxt  = AW'(opnd_a);
        bits_nxt = '0;
        opb_nxt  = opnd_den;
      end else begin
        acc_nxt  = '0;
        bits_nxt = opnd_k;
        opb_nxt  = {1'b0, opnd_a};
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CW'(1);
      if (op_r == skf_pkg::OP_DIV) begin
        acc_nxt  = {acc_keep[AW-2:0], 1'b0};
        bits_nxt = {bits_r[FRAC_BITS-1:0], ge};
      end else begin
        acc_nxt  = add_s[AW-1:0];
        bits_nxt = {bits_r[FRAC_BITS-1:0], 1'b0};
      end
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= skf_pkg::OP_DIV;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    bits_r <= bits_nxt;
    opb_r  <= opb_nxt;
  end

  assign done = done_r;
  assign quot = bits_r;
  assign prod = acc_r[FRAC_BITS +: DATA_WIDTH];

endmodule

>>> rtl/scalar_kalman_filter_core.sv
// top level of the scalar kalman filter core: config registers, sequencer and state
//
//  channel   ports                                   direction
//  input     in_valid, in_stall, in_measurement      measurement z in
//  result    out_valid, out_stall, out_estimate,     estimate and gain out
//            out_gain
//  config    psel, penable, pwrite, paddr, pwdata,   register access
//            prdata, pready
//
//  the core takes no new measurement until it has finished the last one; the gain
//  divide and the two multiplies each run
//  FRAC_BITS+1 steps through the one shared add/subtract unit
//  the result register holds one finished item; a stalled result holds the core in its
//  last step, and a new measurement is taken while a result waits
//  reset is synchronous; it clears the estimate, the variance and the started flag
module scalar_kalman_filter_core #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF,
  localparam int CFG_DW    = (DATA_WIDTH > 32) ? 64 : 32,
  localparam int CFG_AW    = (DATA_WIDTH > 32) ? 5 : 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_measurement,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_estimate,
  output logic [FRAC_BITS:0]           out_gain,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_AW-1:0]            paddr,
  input  logic [CFG_DW-1:0]            pwdata,
  output logic [CFG_DW-1:0]            prdata,
  output logic                         pready
);

  localparam logic [FRAC_BITS:0] ONE_FRAC = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  skf_pkg::state_t state_r, state_nxt;

  logic [DATA_WIDTH-1:0] pnoise_r, mnoise_r, initvar_r;
  logic [1:0]            reg_idx;
  logic                  cfg_wr;

  logic                         started_r, started_nxt;
  logic signed [DATA_WIDTH-1:0] estimate_r, estimate_nxt;
  logic [DATA_WIDTH-1:0]        variance_r, variance_nxt;

  logic signed [DATA_WIDTH-1:0] z_r, z_nxt;
  logic [DATA_WIDTH-1:0]        mag_r, mag_nxt;
  logic                         neg_r, neg_nxt;
  logic                         zero_den_r, zero_den_nxt;
  logic [FRAC_BITS:0]           k_r, k_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] out_estimate_r, out_estimate_nxt;
  logic [FRAC_BITS:0]           out_gain_r, out_gain_nxt;

  skf_pkg::cmd_t         cmd;
  logic [DATA_WIDTH-1:0] opnd_a;
  logic [DATA_WIDTH:0]   opnd_den;
  logic [FRAC_BITS:0]    opnd_k;
  logic                  unit_done;
  logic [FRAC_BITS:0]    unit_quot;
  logic [DATA_WIDTH-1:0] unit_prod;

  logic [DATA_WIDTH:0]          den_sum;
  logic [FRAC_BITS:0]           k_div;
  logic signed [DATA_WIDTH:0]   x_sum;
  logic [DATA_WIDTH:0]          p_sum;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1 -: 2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      skf_pkg::REG_PROCESS_NOISE: prdata = CFG_DW'(pnoise_r);
      skf_pkg::REG_MEAS_NOISE:    prdata = CFG_DW'(mnoise_r);
      skf_pkg::REG_INIT_VARIANCE: prdata = CFG_DW'(initvar_r);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pnoise_r  <= DATA_WIDTH'(skf_pkg::RST_PROCESS_NOISE);
      mnoise_r  <= DATA_WIDTH'(skf_pkg::RST_MEAS_NOISE);
      initvar_r <= DATA_WIDTH'(skf_pkg::RST_INIT_VARIANCE);
    end else if (cfg_wr) begin
      case (reg_idx)
        skf_pkg::REG_PROCESS_NOISE: pnoise_r  <= pwdata[DATA_WIDTH-1:0];
        skf_pkg::REG_MEAS_NOISE:    mnoise_r  <= pwdata[DATA_WIDTH-1:0];
        skf_pkg::REG_INIT_VARIANCE: initvar_r <= pwdata[DATA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // shared arithmetic unit
  skf_iter_unit #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .opnd_a  (opnd_a),
    .opnd_den(opnd_den),
    .opnd_k  (opnd_k),
    .done    (unit_done),
    .quot    (unit_quot),
    .prod    (unit_prod)
  );

  assign in_stall     = (state_r != skf_pkg::ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_estimate = out_estimate_r;
  assign out_gain     = out_gain_r;

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    started_nxt      = started_r;
    estimate_nxt     = estimate_r;
    variance_nxt     = variance_r;
    z_nxt            = z_r;
    mag_nxt          = mag_r;
    neg_nxt          = neg_r;
    zero_den_nxt     = zero_den_r;
    k_nxt            = k_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_estimate_nxt = out_estimate_r;
    out_gain_nxt     = out_gain_r;

    cmd.start = 1'b0;
    cmd.op    = skf_pkg::OP_DIV;
    opnd_a    = variance_r;
    opnd_den  = '0;
    opnd_k    = '0;

    den_sum = {1'b0, variance_r} + {1'b0, mnoise_r};
    k_div   = zero_den_r ? '0 : unit_quot;
    if (neg_r) begin
      x_sum = {estimate_r[DATA_WIDTH-1], estimate_r} - $signed({1'b0, unit_prod});
    end else begin
      x_sum = {estimate_r[DATA_WIDTH-1], estimate_r} + $signed({1'b0, unit_prod});
    end
    p_sum = {1'b0, unit_prod} + {1'b0, pnoise_r};

    case (state_r)
      skf_pkg::ST_IDLE: begin
        if (in_valid) begin
          z_nxt       = in_measurement;
          started_nxt = 1'b1;
          if (!started_r) begin
            variance_nxt = initvar_r;
          end
          state_nxt = skf_pkg::ST_PREP;
        end
      end
      skf_pkg::ST_PREP: begin
        zero_den_nxt = (den_sum == '0);
        neg_nxt      = (z_r < estimate_r);
        mag_nxt      = (z_r < estimate_r) ? DATA_WIDTH'(estimate_r - z_r)
                                          : DATA_WIDTH'(z_r - estimate_r);
        cmd.start    = 1'b1;
        cmd.op       = skf_pkg::OP_DIV;
        opnd_a       = variance_r;
        opnd_den     = den_sum;
        state_nxt    = skf_pkg::ST_DIV;
      end
      skf_pkg::ST_DIV: begin
        if (unit_done) begin
          k_nxt     = k_div;
          cmd.start = 1'b1;
          cmd.op    = skf_pkg::OP_MUL;
          opnd_a    = mag_r;
          opnd_k    = k_div;
          state_nxt = skf_pkg::ST_MUL_EST;
        end
      end
      skf_pkg::ST_MUL_EST: begin
        if (unit_done) begin
          if (x_sum[DATA_WIDTH] != x_sum[DATA_WIDTH-1]) begin
            estimate_nxt = x_sum[DATA_WIDTH] ? SMIN : SMAX;
          end else begin
            estimate_nxt = x_sum[DATA_WIDTH-1:0];
          end
          cmd.start = 1'b1;
          cmd.op    = skf_pkg::OP_MUL;
          opnd_a    = variance_r;
          opnd_k    = ONE_FRAC - k_r;
          state_nxt = skf_pkg::ST_MUL_VAR;
        end
      end
      skf_pkg::ST_MUL_VAR: begin
        if (unit_done) begin
          variance_nxt = p_sum[DATA_WIDTH] ? '1 : p_sum[DATA_WIDTH-1:0];
          state_nxt    = skf_pkg::ST_OUT;
        end
      end
      skf_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_estimate_nxt = estimate_r;
          out_gain_nxt     = k_r;
          state_nxt        = skf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = skf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skf_pkg::ST_IDLE;
      started_r   <= 1'b0;
      estimate_r  <= '0;
      variance_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      estimate_r  <= estimate_nxt;
      variance_r  <= variance_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r            <= z_nxt;
    mag_r          <= mag_nxt;
    neg_r          <= neg_nxt;
    zero_den_r     <= zero_den_nxt;
    k_r            <= k_nxt;
    out_estimate_r <= out_estimate_nxt;
    out_gain_r     <= out_gain_nxt;
  end

endmodule
